// ===== hdl/sbdm_pkg.sv =====
`default_nettype none

package sbdm_pkg;

	// Frame layout
	localparam int FRAME_BYTES = 25;
	localparam int IDX_W       = 5;
	localparam int BODY_FIRST  = 1;
	localparam int BODY_LAST   = 22;
	localparam int BODY_BITS   = 8 * (BODY_LAST - BODY_FIRST + 1);
	localparam int CH_BITS     = 11;
	localparam int CH_SEL_W    = 4;

	localparam logic [7:0] SYNC_BYTE    = 8'h0F;
	localparam logic [7:0] ZERO_BYTE    = 8'h00;
	localparam int         FAILSAFE_POS = 3;

	// Smoothing filter, unsigned 11.F fixed point
	localparam int FILT_FRAC = 8;
	localparam int FILT_W    = CH_BITS + FILT_FRAC;

	// Output mapping
	localparam int CODE_W   = 12;
	localparam int DB_W     = 8;
	localparam int COEF_W   = 12;
	localparam int PROD_W   = CH_BITS + COEF_W;
	localparam int RECIP_W  = 23;
	localparam int RECIP_SH = 32;

	localparam logic [CH_BITS-1:0] MID_VALUE   = 11'd1000;
	localparam logic [CODE_W-1:0]  CENTER_CODE = 12'd1817;
	localparam logic [CODE_W-1:0]  MAX_CODE    = 12'd4095;
	localparam logic [COEF_W-1:0]  COEF_UPPER  = 12'd2278;
	localparam logic [COEF_W-1:0]  COEF_LOWER  = 12'd1817;

	// Ceiling reciprocals of the two divisors (1047 above center, 1000 below).
	// Products stay below 2^23, so the rounding error never reaches 1/divisor
	// and the truncated quotient is exact without a correction step.
	localparam longint unsigned RECIP_HI_L = ((64'd1 << RECIP_SH) + 64'd1046) / 64'd1047;
	localparam longint unsigned RECIP_LO_L = ((64'd1 << RECIP_SH) + 64'd999) / 64'd1000;
	localparam logic [RECIP_W-1:0] RECIP_HI = RECIP_W'(RECIP_HI_L);
	localparam logic [RECIP_W-1:0] RECIP_LO = RECIP_W'(RECIP_LO_L);

	localparam logic [FILT_W-1:0] FILT_RESET = {MID_VALUE, {FILT_FRAC{1'b0}}};

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT_CH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_CH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT_SWAP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_SWAP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND  = 3'd4;

	// Frame decoder status toward the top level
	typedef struct packed {
		logic last_slot;  // next stored byte completes the frame
		logic done_s1;    // a good frame was just captured
	} frame_stat_t;

	// Stage enables for the channel pipelines
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} stage_en_t;

endpackage

`default_nettype wire

// ===== hdl/sbdm_if.sv =====
`default_nettype none

// Byte request channel
interface sbdm_in_if;
	import sbdm_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// Result request channel
interface sbdm_out_if;
	import sbdm_pkg::*;

	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] left_code;
	logic [CODE_W-1:0] right_code;
	logic [CH_BITS-1:0] left_raw;
	logic [CH_BITS-1:0] right_raw;

	modport source (output valid, output left_code, output right_code,
		output left_raw, output right_raw, input ready);
	modport sink (input valid, input left_code, input right_code,
		input left_raw, input right_raw, output ready);
endinterface

`default_nettype wire

// ===== hdl/sbdm_frame.sv =====
`default_nettype none

module sbdm_frame (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic [7:0]                    rx_byte,
	input  wire logic [sbdm_pkg::CH_SEL_W-1:0] left_ch,
	input  wire logic [sbdm_pkg::CH_SEL_W-1:0] right_ch,
	output sbdm_pkg::frame_stat_t              stat,
	output logic [sbdm_pkg::CH_BITS-1:0]       left_raw_s1,
	output logic [sbdm_pkg::CH_BITS-1:0]       right_raw_s1
);
	import sbdm_pkg::*;

	logic [IDX_W-1:0]     idx_q;
	logic [7:0]           prev_q;
	logic                 sync_ok_q;
	logic [BODY_BITS-1:0] body_q;
	logic                 done_s1;

	logic             resync;
	logic [IDX_W-1:0] idx_eff;
	logic             wr;
	logic             done;

	// Sync pair restarts the index; bytes past a full frame are dropped
	always_comb begin
		resync  = (prev_q == ZERO_BYTE) && (rx_byte == SYNC_BYTE);
		idx_eff = resync ? '0 : idx_q;
		wr      = accept && (idx_eff < IDX_W'(FRAME_BYTES));
		// byte 23 is the byte accepted just before the last one
		done    = wr && (idx_eff == IDX_W'(FRAME_BYTES - 1)) && sync_ok_q &&
			!prev_q[FAILSAFE_POS];
	end

	// Index, previous byte and completion flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			prev_q  <= '0;
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= done;
			if (accept) begin
				prev_q <= rx_byte;
				if (wr)
					idx_q <= idx_eff + IDX_W'(1);
			end
		end
	end

	// Frame body storage, one byte lane per position
	always_ff @(posedge clk) begin
		if (wr && (idx_eff == '0))
			sync_ok_q <= (rx_byte == SYNC_BYTE);
		for (int i = BODY_FIRST; i <= BODY_LAST; i++) begin
			if (wr && (idx_eff == IDX_W'(i)))
				body_q[8*(i-BODY_FIRST) +: 8] <= rx_byte;
		end
	end

	// Channel extraction at frame completion
	always_ff @(posedge clk) begin
		if (done) begin
			left_raw_s1  <= body_q[CH_BITS*left_ch +: CH_BITS];
			right_raw_s1 <= body_q[CH_BITS*right_ch +: CH_BITS];
		end
	end

	assign stat.last_slot = (idx_q == IDX_W'(FRAME_BYTES - 1));
	assign stat.done_s1   = done_s1;

endmodule

`default_nettype wire

// ===== hdl/sbdm_chan.sv =====
`default_nettype none

module sbdm_chan (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  sbdm_pkg::stage_en_t              en,
	input  wire logic                        swap,
	input  wire logic [sbdm_pkg::DB_W-1:0]   deadband,
	input  wire logic [sbdm_pkg::CH_BITS-1:0] raw_s1,
	output logic [sbdm_pkg::CODE_W-1:0]      code,
	output logic [sbdm_pkg::CH_BITS-1:0]     raw_out
);
	import sbdm_pkg::*;

	localparam logic [FILT_W-1:0] MID_FX = {MID_VALUE, {FILT_FRAC{1'b0}}};
	localparam int SUM_W  = FILT_W + 1;
	localparam int MULQ_W = PROD_W + RECIP_W;

	logic [FILT_W-1:0]  filt_q;
	logic [FILT_W-1:0]  f_s2;
	logic [CH_BITS-1:0] raw_s2, raw_s3, raw_s4;
	logic [PROD_W-1:0]  p_s3;
	logic               cen_s3, above_s3, cen_s4, above_s4;
	logic [CODE_W-1:0]  q_s4;

	logic [SUM_W-1:0]   sum;
	logic [FILT_W-1:0]  f_new;
	logic [FILT_W-1:0]  diff;
	logic               cen, above;
	logic [CH_BITS-1:0] x, op;
	logic [COEF_W-1:0]  coef;
	logic [MULQ_W-1:0]  mq;

	// Smoothing step: f = (f + new) / 2, truncated
	always_comb begin
		sum   = SUM_W'(filt_q) + SUM_W'({raw_s1, {FILT_FRAC{1'b0}}});
		f_new = sum[SUM_W-1:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			filt_q <= FILT_RESET;
		else if (en.s1)
			filt_q <= f_new;
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			f_s2   <= f_new;
			raw_s2 <= raw_s1;
		end
	end

	// Center zone test and numerator of the linear map
	always_comb begin
		above = (f_s2 > MID_FX);
		diff  = above ? (f_s2 - MID_FX) : (MID_FX - f_s2);
		cen   = (diff < FILT_W'({deadband, {FILT_FRAC{1'b0}}}));
		x     = f_s2[FILT_W-1:FILT_FRAC];
		op    = above ? (x - MID_VALUE) : x;
		coef  = (above == swap) ? COEF_UPPER : COEF_LOWER;
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			p_s3     <= PROD_W'(op) * PROD_W'(coef);
			cen_s3   <= cen;
			above_s3 <= above;
			raw_s3   <= raw_s2;
		end
	end

	// Constant division by reciprocal multiply
	assign mq = MULQ_W'(p_s3) * MULQ_W'(above_s3 ? RECIP_HI : RECIP_LO);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			q_s4     <= mq[RECIP_SH +: CODE_W];
			cen_s4   <= cen_s3;
			above_s4 <= above_s3;
			raw_s4   <= raw_s3;
		end
	end

	// Final code around the center
	always_comb begin
		priority if (cen_s4)
			code = CENTER_CODE;
		else if (above_s4)
			code = swap ? (CENTER_CODE + q_s4) : (CENTER_CODE - q_s4);
		else
			code = swap ? q_s4 : (MAX_CODE - q_s4);
	end

	assign raw_out = raw_s4;

endmodule

`default_nettype wire

// ===== hdl/sbus_to_dual_dac_mapper.sv =====
// SBUS byte stream to dual DAC code mapper.
//
// in_ch carries one received SBUS byte per request; out_ch carries one
// result per good frame: two 12-bit DAC codes and the two raw 11-bit
// channel values they came from. cfg_we/cfg_idx/cfg_data write the channel
// selects, swap bits and deadband; write them only while no frame is in
// flight.
//
// Throughput: one byte per cycle while in_ch.ready is high. A result appears
// on out_ch once the request that carries the 25th byte of a good frame has
// passed capture and extraction, filter update, center test and numerator
// multiply, reciprocal multiply and the output register.
// Backpressure: the output register holds one result. in_ch.ready drops
// only when the next stored byte would complete a frame while a result is
// still in the pipeline or waiting on out_ch; all other bytes are taken
// while out_ch is stalled.
// Reset (arst_n low) clears the frame index, the previous byte, the
// pipeline valids and the output valid, returns both filters to 1000.0
// and loads the default configuration.

`default_nettype none

module sbus_to_dual_dac_mapper (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	sbdm_in_if.sink                              in_ch,
	sbdm_out_if.source                           out_ch,
	input  wire logic                            cfg_we,
	input  wire logic [sbdm_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [sbdm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sbdm_pkg::*;

	logic [CH_SEL_W-1:0] left_ch_q, right_ch_q;
	logic                left_swap_q, right_swap_q;
	logic [DB_W-1:0]     deadband_q;

	frame_stat_t         fstat;
	stage_en_t           en;
	logic                v_s2, v_s3, v_s4;
	logic                out_valid_q;
	logic                busy;
	logic                accept;

	logic [CH_BITS-1:0]  left_raw_s1, right_raw_s1;
	logic [CODE_W-1:0]   left_code, right_code;
	logic [CH_BITS-1:0]  left_raw, right_raw;

	logic [CODE_W-1:0]   left_code_q, right_code_q;
	logic [CH_BITS-1:0]  left_raw_q, right_raw_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_ch_q    <= CH_SEL_W'(0);
			right_ch_q   <= CH_SEL_W'(2);
			left_swap_q  <= 1'b0;
			right_swap_q <= 1'b1;
			deadband_q   <= DB_W'(20);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_LEFT_CH:    left_ch_q    <= cfg_data[CH_SEL_W-1:0];
				CFG_RIGHT_CH:   right_ch_q   <= cfg_data[CH_SEL_W-1:0];
				CFG_LEFT_SWAP:  left_swap_q  <= cfg_data[0];
				CFG_RIGHT_SWAP: right_swap_q <= cfg_data[0];
				CFG_DEADBAND:   deadband_q   <= cfg_data[DB_W-1:0];
				default: ;
			endcase
		end
	end

	// Input flow control: hold only the frame-completing byte
	assign busy        = fstat.done_s1 | v_s2 | v_s3 | v_s4 | out_valid_q;
	assign in_ch.ready = !(fstat.last_slot && busy);
	assign accept      = in_ch.valid && in_ch.ready;

	sbdm_frame u_frame (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.rx_byte      (in_ch.rx_byte),
		.left_ch      (left_ch_q),
		.right_ch     (right_ch_q),
		.stat         (fstat),
		.left_raw_s1  (left_raw_s1),
		.right_raw_s1 (right_raw_s1)
	);

	// Pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= fstat.done_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign en.s1 = fstat.done_s1;
	assign en.s2 = v_s2;
	assign en.s3 = v_s3;

	sbdm_chan u_left (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.swap     (left_swap_q),
		.deadband (deadband_q),
		.raw_s1   (left_raw_s1),
		.code     (left_code),
		.raw_out  (left_raw)
	);

	sbdm_chan u_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.swap     (right_swap_q),
		.deadband (deadband_q),
		.raw_s1   (right_raw_s1),
		.code     (right_code),
		.raw_out  (right_raw)
	);

	// Output register; loaded whenever a result leaves the last stage, emptied when out_ch takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (v_s4)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (v_s4) begin
			left_code_q  <= left_code;
			right_code_q <= right_code;
			left_raw_q   <= left_raw;
			right_raw_q  <= right_raw;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.left_code  = left_code_q;
	assign out_ch.right_code = right_code_q;
	assign out_ch.left_raw   = left_raw_q;
	assign out_ch.right_raw  = right_raw_q;

endmodule

`default_nettype wire

// ===== hdl/sbdm_checker.sv =====
`default_nettype none

module sbdm_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [sbdm_pkg::CODE_W-1:0]   left_code,
	input wire logic [sbdm_pkg::CODE_W-1:0]   right_code,
	input wire logic [sbdm_pkg::CH_BITS-1:0]  left_raw,
	input wire logic [sbdm_pkg::CH_BITS-1:0]  right_raw
);
	import sbdm_pkg::*;

	// Stalled result stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// Stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(left_code) && $stable(right_code) &&
			$stable(left_raw) && $stable(right_raw))
		else $error("result payload changed while stalled");

	// A new result traces back to an accepted completing byte
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 5))
		else $error("result without a byte five cycles earlier");

	// Single result buffer: a taken result is never followed at once
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid)
		else $error("back-to-back results from the single buffer");

endmodule

bind sbus_to_dual_dac_mapper sbdm_checker u_sbdm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.left_code  (out_ch.left_code),
	.right_code (out_ch.right_code),
	.left_raw   (out_ch.left_raw),
	.right_raw  (out_ch.right_raw)
);

`default_nettype wire
